### src/priority_lock_arbiter_defines.svh
// assertion macros shared by the priority lock arbiter rtl
// expects clk and rst to be visible in the module that uses them
`ifndef PRIORITY_LOCK_ARBITER_DEFINES_SVH
`define PRIORITY_LOCK_ARBITER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PLK_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plk assertion failed");

// next-cycle implication, checked outside reset
`define PLK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plk assertion failed");

`endif

### src/plk_pkg.sv
// shared constants, codes and types of the priority lock arbiter
// no dependencies
`default_nettype none

package plk_pkg;

  localparam int WAIT_DEPTH = 16;
  localparam int LEVEL_BITS = 8;

  // stored level width, the level port carries at most eight bits
  localparam int LVL_W = (LEVEL_BITS < 8) ? LEVEL_BITS : 8;
  localparam int IDX_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int CNT_W = $clog2(WAIT_DEPTH + 1);

  // beat kind
  localparam logic KIND_REQ = 1'b0;
  localparam logic KIND_REL = 1'b1;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_FULL     = 3'd2,
    ST_FREED    = 3'd3,
    ST_REL_FREE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

endpackage

`default_nettype wire

### src/plk_ram.sv
// simple dual port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module plk_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/priority_lock_arbiter.sv
// priority lock arbiter: lock with a priority-ordered wait list
// depends on plk_pkg, plk_ram and priority_lock_arbiter_defines.svh
//
// usage: drive kind and level with start high; a beat is taken at a rising
// edge with start high and busy low. kind 0 asks for the lock, kind 1
// releases it. each beat gives exactly one result, shown for one cycle on
// status, grant_valid, granted_level and waiting_count with done high; the
// receiver has no way to hold it and must take it in that cycle.
// a request, a release while free and a release with nobody waiting give
// their result in the cycle after the beat, and busy stays low, so such
// beats may follow every cycle.
// a release with n waiters runs a scan over the wait list through the
// ram's single read port, one entry per cycle, then closes the gap left
// by the winner by moving the younger entries down one per cycle, busy
// high throughout. the wait list is kept in arrival order, so the first
// highest level found in the scan is the oldest.
// reset (rst, synchronous) frees the lock and empties the wait list; ram
// contents are not cleared, the fill count alone marks what is valid.
`default_nettype none
`include "priority_lock_arbiter_defines.svh"

module priority_lock_arbiter
  import plk_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       kind,
  input  wire logic [7:0] level,
  output logic            done,
  output logic [2:0]      status,
  output logic            grant_valid,
  output logic [7:0]      granted_level,
  output logic [4:0]      waiting_count
);

  state_t             state, state_next;
  logic               held, held_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [CNT_W-1:0]   ptr, ptr_next;
  logic               rd_vld, rd_vld_next;
  logic [IDX_W-1:0]   rd_idx, rd_idx_next;
  logic [LVL_W-1:0]   best_lvl, best_lvl_next;
  logic [IDX_W-1:0]   best_idx, best_idx_next;

  logic               acc;
  logic               issue;
  logic               take;
  logic [LVL_W-1:0]   win_lvl;
  logic [IDX_W-1:0]   win_idx;
  logic               last_cmp;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [LVL_W-1:0]   wdata;
  logic [IDX_W-1:0]   raddr;
  logic [LVL_W-1:0]   rdata;

  logic               done_next;
  status_t            res_status;
  logic               res_gvalid;
  logic [LVL_W-1:0]   res_level;

  assign busy  = (state != S_IDLE);
  assign acc   = start && !busy;
  assign issue = (ptr < cnt);
  assign raddr = ptr[IDX_W-1:0];

  // compare unit of the scan: first entry or strictly higher level wins
  assign take     = (rd_idx == '0) || (rdata > best_lvl);
  assign win_lvl  = take ? rdata : best_lvl;
  assign win_idx  = take ? rd_idx : best_idx;
  assign last_cmp = rd_vld && (CNT_W'(rd_idx) == cnt - CNT_W'(1));

  // wait list storage, kept in arrival order
  plk_ram #(
    .DEPTH (WAIT_DEPTH),
    .WIDTH (LVL_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc && kind == KIND_REL && held && cnt != '0) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_cmp) begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (!issue && !rd_vld) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and result control
  always_comb begin
    held_next     = held;
    cnt_next      = cnt;
    ptr_next      = ptr;
    rd_vld_next   = 1'b0;
    rd_idx_next   = rd_idx;
    best_lvl_next = best_lvl;
    best_idx_next = best_idx;
    we            = 1'b0;
    waddr         = cnt[IDX_W-1:0];
    wdata         = level[LVL_W-1:0];
    done_next     = 1'b0;
    res_status    = ST_GRANTED;
    res_gvalid    = 1'b0;
    res_level     = '0;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          done_next = 1'b1;
          if (kind == KIND_REQ) begin
            if (!held) begin
              held_next  = 1'b1;
              res_status = ST_GRANTED;
              res_gvalid = 1'b1;
              res_level  = level[LVL_W-1:0];
            end else if (cnt >= CNT_W'(WAIT_DEPTH)) begin
              res_status = ST_FULL;
            end else begin
              we         = 1'b1;
              cnt_next   = cnt + CNT_W'(1);
              res_status = ST_QUEUED;
            end
          end else if (!held) begin
            res_status = ST_REL_FREE;
          end else if (cnt == '0) begin
            held_next  = 1'b0;
            res_status = ST_FREED;
          end else begin
            // long release, result comes at the end of the shift pass
            done_next = 1'b0;
            ptr_next  = '0;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          ptr_next    = ptr + CNT_W'(1);
          rd_vld_next = 1'b1;
          rd_idx_next = ptr[IDX_W-1:0];
        end
        if (rd_vld) begin
          best_lvl_next = win_lvl;
          best_idx_next = win_idx;
        end
        if (last_cmp) begin
          rd_vld_next = 1'b0;
          ptr_next    = CNT_W'(win_idx) + CNT_W'(1);
        end
      end
      S_SHIFT: begin
        if (issue) begin
          ptr_next    = ptr + CNT_W'(1);
          rd_vld_next = 1'b1;
          rd_idx_next = ptr[IDX_W-1:0];
        end
        // move the entry just read one place toward the head
        if (rd_vld) begin
          we    = 1'b1;
          waddr = rd_idx - IDX_W'(1);
          wdata = rdata;
        end
        if (!issue && !rd_vld) begin
          cnt_next   = cnt - CNT_W'(1);
          done_next  = 1'b1;
          res_status = ST_GRANTED;
          res_gvalid = 1'b1;
          res_level  = best_lvl;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      held   <= 1'b0;
      cnt    <= '0;
      rd_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      held   <= held_next;
      cnt    <= cnt_next;
      rd_vld <= rd_vld_next;
      done   <= done_next;
    end
  end

  // sequencer payload and result beat
  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    rd_idx   <= rd_idx_next;
    best_lvl <= best_lvl_next;
    best_idx <= best_idx_next;
    if (done_next) begin
      status        <= res_status;
      grant_valid   <= res_gvalid;
      granted_level <= 8'(res_level);
      waiting_count <= 5'(cnt_next);
    end
  end

  `PLK_ASSERT_IMPL(a_cnt_range, 1'b1, cnt <= CNT_W'(WAIT_DEPTH))
  `PLK_ASSERT_IMPL(a_wait_needs_holder, cnt != '0, held)
  `PLK_ASSERT_IMPL(a_scan_nonempty, state == S_SCAN, cnt != '0)
  `PLK_ASSERT_NEXT(a_rel_free, acc && kind == KIND_REL && !held, done && status == ST_REL_FREE)
  `PLK_ASSERT_IMPL(a_grant_held, done && grant_valid, held)

endmodule

`default_nettype wire
